// File: src/erhp_pkg.sv
package erhp_pkg;

   localparam int LAYER_SLOTS_DEF = 64;
   localparam int MAX_EXPERTS_DEF = 256;
   localparam int COUNT_BITS_DEF  = 32;

   localparam int SUM_BITS  = 40;
   localparam int PROD_BITS = 47;
   localparam int NUM_K     = 5;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
   localparam logic [8:0] EXPERT_COUNT_RESET = 9'd256;

   localparam int unsigned TOP_K [NUM_K] = '{8, 16, 32, 64, 128};
   localparam logic [6:0]  PCT   [NUM_K] = '{7'd50, 7'd80, 7'd90, 7'd95, 7'd99};
   localparam logic [6:0]  HUNDRED = 7'd100;

   typedef enum logic [0:0] {
      OP_RECORD = 1'b0,
      OP_REPORT = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_RECORDED = 2'd0,
      STATUS_IGNORED  = 2'd1,
      STATUS_REPORT   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REC,
      ST_SCAN,
      ST_THR,
      ST_EMIT,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [5:0]        layer;
      logic signed [31:0] expert_id;
   } req_type;

   typedef struct packed {
      status_type    status;
      logic [39:0]   layer_total;
      logic [39:0]   top8_sum;
      logic [39:0]   top16_sum;
      logic [39:0]   top32_sum;
      logic [39:0]   top64_sum;
      logic [39:0]   top128_sum;
      logic [8:0]    experts_for_half;
      logic [8:0]    experts_for_eighty;
      logic [8:0]    experts_for_ninety;
      logic [8:0]    experts_for_ninety_five;
      logic [8:0]    experts_for_ninety_nine;
   } rsp_type;

endpackage

// File: src/erhp_count_ram.sv
module erhp_count_ram #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 32,
   parameter int AW    = 14
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/expert_route_histogram_profiler.sv
// Per-layer expert pick histogram with top-k coverage reports. A record beat
// reads its counter from memory, then writes it back saturated; an id out of
// range is answered in the next cycle. A report scans the layer's MAX_EXPERTS
// counters once for the total and largest count, then, unless the layer is
// empty, once more for each further distinct count value, each scan followed
// by accumulating its experts one at a time, the scans running in series on
// the single read port of the counter memory; a layer out of range is answered
// with no scan. After reset a clearing pass zeroes all LAYER_SLOTS*MAX_EXPERTS
// counters with busy high; csr writes are taken during it. Each result is on
// rsp_data for exactly one cycle with rsp_valid high and cannot be stalled by the receiver.
module expert_route_histogram_profiler #(
   parameter int LAYER_SLOTS = erhp_pkg::LAYER_SLOTS_DEF,
   parameter int MAX_EXPERTS = erhp_pkg::MAX_EXPERTS_DEF,
   parameter int COUNT_BITS  = erhp_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  erhp_pkg::req_type req_data,
   output logic              rsp_valid,
   output erhp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [8:0]        csr_wdata
);

   localparam int DEPTH = LAYER_SLOTS * MAX_EXPERTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = $clog2(MAX_EXPERTS);
   localparam int NW    = $clog2(MAX_EXPERTS + 1);
   localparam int SB    = erhp_pkg::SUM_BITS;
   localparam int PB    = erhp_pkg::PROD_BITS;
   localparam int NK    = erhp_pkg::NUM_K;
   localparam logic [8:0]  LAYER_LIM = 9'(LAYER_SLOTS);
   localparam logic [10:0] MAX_LIM   = 11'(MAX_EXPERTS);
   localparam logic [NW-1:0] N_ALL   = NW'(MAX_EXPERTS);

   function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] a,
                                             input logic [COUNT_BITS-1:0] b);
      logic [SB:0] s;
      s = {1'b0, a} + (SB+1)'(b);
      if (64'(b) > 64'(erhp_pkg::SUM_MAX) || s > (SB+1)'(erhp_pkg::SUM_MAX)) begin
         return erhp_pkg::SUM_MAX;
      end
      return s[SB-1:0];
   endfunction

   erhp_pkg::state_type state_ff, state_in;
   logic [8:0]            csr_ff;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [AW-1:0]         rec_addr_ff, rec_addr_in;
   logic [NW-1:0]         issue_ff, issue_in;
   logic                  vld_ff, vld_in;
   logic                  first_ff, first_in;
   logic                  have_ff, have_in;
   logic [COUNT_BITS-1:0] best_ff, best_in;
   logic [COUNT_BITS-1:0] thr_val_ff, thr_val_in;
   logic [NW-1:0]         mult_ff, mult_in;
   logic [NW-1:0]         emitted_ff, emitted_in;
   logic [SB-1:0]         total_ff, total_in;
   logic [SB-1:0]         cum_ff, cum_in;
   logic                  chk_ff, chk_in;
   logic [PB-1:0]         thrk_ff [NK];
   logic [PB-1:0]         thrk_in [NK];
   logic [SB-1:0]         topk_ff [NK];
   logic [SB-1:0]         topk_in [NK];
   logic [8:0]            expk_ff [NK];
   logic [8:0]            expk_in [NK];
   logic [NK-1:0]         hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   erhp_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [COUNT_BITS-1:0] rd_data, wr_data;

   logic          accept, lay_ok, rec_ok, scan_end, grp_last, all_done;
   logic [10:0]   limit;
   logic [AW-1:0] layer_base;
   logic [PB-1:0] cum100;

   erhp_count_ram #(
      .DEPTH(DEPTH),
      .WIDTH(COUNT_BITS),
      .AW   (AW)
   ) u_ram (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   assign accept     = start && !busy;
   assign limit      = (11'(csr_ff) > MAX_LIM) ? MAX_LIM : 11'(csr_ff);
   assign lay_ok     = {3'b000, req_data.layer} < LAYER_LIM;
   assign rec_ok     = lay_ok && !req_data.expert_id[31]
                       && (32'(req_data.expert_id) < 32'(limit));
   assign layer_base = AW'(AW'(req_data.layer) * AW'(MAX_EXPERTS));
   assign scan_end   = (issue_ff == N_ALL) && !vld_ff;
   assign grp_last   = mult_ff == NW'(1);
   assign all_done   = (emitted_ff + NW'(1)) == N_ALL;
   assign cum100     = PB'(cum_ff) * PB'(erhp_pkg::HUNDRED);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         erhp_pkg::ST_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) state_in = erhp_pkg::ST_IDLE;
         end
         erhp_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == erhp_pkg::OP_RECORD) begin
                  if (rec_ok) state_in = erhp_pkg::ST_REC;
               end else if (lay_ok) begin
                  state_in = erhp_pkg::ST_SCAN;
               end
            end
         end
         erhp_pkg::ST_REC: state_in = erhp_pkg::ST_IDLE;
         erhp_pkg::ST_SCAN: begin
            if (scan_end) begin
               if (!first_ff)          state_in = erhp_pkg::ST_EMIT;
               else if (total_ff == '0) state_in = erhp_pkg::ST_IDLE;
               else                    state_in = erhp_pkg::ST_THR;
            end
         end
         erhp_pkg::ST_THR: state_in = erhp_pkg::ST_EMIT;
         erhp_pkg::ST_EMIT: begin
            if (grp_last) state_in = all_done ? erhp_pkg::ST_FIN : erhp_pkg::ST_SCAN;
         end
         erhp_pkg::ST_FIN:  state_in = erhp_pkg::ST_DONE;
         erhp_pkg::ST_DONE: state_in = erhp_pkg::ST_IDLE;
         default:           state_in = erhp_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      base_in      = base_ff;
      rec_addr_in  = rec_addr_ff;
      issue_in     = issue_ff;
      vld_in       = 1'b0;
      first_in     = first_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      thr_val_in   = thr_val_ff;
      mult_in      = mult_ff;
      emitted_in   = emitted_ff;
      total_in     = total_ff;
      cum_in       = cum_ff;
      chk_in       = 1'b0;
      thrk_in      = thrk_ff;
      topk_in      = topk_ff;
      expk_in      = expk_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      // coverage check on the sum after the previous expert
      if (chk_ff) begin
         for (int k = 0; k < NK; k++) begin
            if (!hit_ff[k] && cum100 >= thrk_ff[k]) begin
               hit_in[k]  = 1'b1;
               expk_in[k] = 9'(emitted_ff);
            end
            if (emitted_ff == NW'(erhp_pkg::TOP_K[k])) topk_in[k] = cum_ff;
         end
      end

      case (state_ff)
         erhp_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         erhp_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == erhp_pkg::OP_RECORD) begin
                  if (rec_ok) begin
                     rd_en       = 1'b1;
                     rd_addr     = layer_base + AW'(req_data.expert_id[EW-1:0]);
                     rec_addr_in = rd_addr;
                  end else begin
                     rsp_valid_in       = 1'b1;
                     rsp_data_in.status = erhp_pkg::STATUS_IGNORED;
                  end
               end else if (lay_ok) begin
                  base_in    = layer_base;
                  issue_in   = '0;
                  first_in   = 1'b1;
                  have_in    = 1'b0;
                  total_in   = '0;
                  cum_in     = '0;
                  emitted_in = '0;
                  hit_in     = '0;
                  for (int k = 0; k < NK; k++) begin
                     topk_in[k] = '0;
                     expk_in[k] = '0;
                  end
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = erhp_pkg::STATUS_REPORT;
               end
            end
         end
         erhp_pkg::ST_REC: begin
            wr_en              = 1'b1;
            wr_addr            = rec_addr_ff;
            wr_data            = (&rd_data) ? rd_data : rd_data + COUNT_BITS'(1);
            rsp_valid_in       = 1'b1;
            rsp_data_in.status = erhp_pkg::STATUS_RECORDED;
         end
         erhp_pkg::ST_SCAN: begin
            if (issue_ff != N_ALL) begin
               rd_en    = 1'b1;
               rd_addr  = base_ff + AW'(issue_ff[EW-1:0]);
               issue_in = issue_ff + NW'(1);
               vld_in   = 1'b1;
            end
            // largest count below the previous group's value, with multiplicity
            if (vld_ff) begin
               if (first_ff) total_in = sat_add(total_ff, rd_data);
               if (first_ff || rd_data < thr_val_ff) begin
                  have_in = 1'b1;
                  if (!have_ff || rd_data > best_ff) begin
                     best_in = rd_data;
                     mult_in = NW'(1);
                  end else if (rd_data == best_ff) begin
                     mult_in = mult_ff + NW'(1);
                  end
               end
            end
            if (scan_end && first_ff && total_ff == '0) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = erhp_pkg::STATUS_REPORT;
            end
         end
         erhp_pkg::ST_THR: begin
            for (int k = 0; k < NK; k++) begin
               thrk_in[k] = PB'(total_ff) * PB'(erhp_pkg::PCT[k]);
            end
         end
         erhp_pkg::ST_EMIT: begin
            cum_in     = sat_add(cum_ff, best_ff);
            emitted_in = emitted_ff + NW'(1);
            mult_in    = mult_ff - NW'(1);
            chk_in     = 1'b1;
            if (grp_last) begin
               thr_val_in = best_ff;
               first_in   = 1'b0;
               have_in    = 1'b0;
               issue_in   = '0;
            end
         end
         erhp_pkg::ST_FIN: begin
         end
         erhp_pkg::ST_DONE: begin
            rsp_valid_in                        = 1'b1;
            rsp_data_in.status                  = erhp_pkg::STATUS_REPORT;
            rsp_data_in.layer_total             = total_ff;
            rsp_data_in.top8_sum                = topk_ff[0];
            rsp_data_in.top16_sum               = topk_ff[1];
            rsp_data_in.top32_sum               = topk_ff[2];
            rsp_data_in.top64_sum               = topk_ff[3];
            rsp_data_in.top128_sum              = topk_ff[4];
            rsp_data_in.experts_for_half        = expk_ff[0];
            rsp_data_in.experts_for_eighty      = expk_ff[1];
            rsp_data_in.experts_for_ninety      = expk_ff[2];
            rsp_data_in.experts_for_ninety_five = expk_ff[3];
            rsp_data_in.experts_for_ninety_nine = expk_ff[4];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= erhp_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         csr_ff       <= erhp_pkg::EXPERT_COUNT_RESET;
         vld_ff       <= 1'b0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         vld_ff       <= vld_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) csr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      rec_addr_ff <= rec_addr_in;
      issue_ff    <= issue_in;
      first_ff    <= first_in;
      have_ff     <= have_in;
      best_ff     <= best_in;
      thr_val_ff  <= thr_val_in;
      mult_ff     <= mult_in;
      emitted_ff  <= emitted_in;
      total_ff    <= total_in;
      cum_ff      <= cum_in;
      thrk_ff     <= thrk_in;
      topk_ff     <= topk_in;
      expk_ff     <= expk_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = state_ff != erhp_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ignored_next: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.opcode == erhp_pkg::OP_RECORD && !rec_ok) |=>
         (rsp_valid && rsp_data.status == erhp_pkg::STATUS_IGNORED))
      else $error("ignored pick not answered in the next cycle");

   a_record_two: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.opcode == erhp_pkg::OP_RECORD && rec_ok) |=>
         ##1 (rsp_valid && rsp_data.status == erhp_pkg::STATUS_RECORDED))
      else $error("recorded pick not answered after write-back");

   a_top_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == erhp_pkg::STATUS_REPORT) |->
         (rsp_data.top8_sum <= rsp_data.top16_sum
          && rsp_data.top16_sum <= rsp_data.top32_sum
          && rsp_data.top32_sum <= rsp_data.top64_sum
          && rsp_data.top64_sum <= rsp_data.top128_sum
          && rsp_data.top128_sum <= rsp_data.layer_total))
      else $error("top sums out of order");

endmodule

// File: bench/tb_expert_route_histogram_profiler.sv
`timescale 1ns / 100ps

module tb_expert_route_histogram_profiler;

   localparam int WATCHDOG_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   erhp_pkg::req_type req_data = '0;
   logic    rsp_valid;
   erhp_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [8:0] csr_wdata = '0;

   erhp_pkg::req_type pending_beats[$];
   erhp_pkg::rsp_type expected_rsps[$];
   logic [31:0] hist [64][256];
   logic [8:0]  expert_limit_reg;
   int          idle_mode = 0;
   int          errors = 0;
   int          quiet_cycles = 0;

   expert_route_histogram_profiler i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [39:0] sat_sum(logic [39:0] a, logic [31:0] b);
      logic [40:0] s;
      s = {1'b0, a} + b;
      return s[40] ? erhp_pkg::SUM_MAX : s[39:0];
   endfunction

   function automatic erhp_pkg::rsp_type histogram_response(erhp_pkg::req_type r);
      erhp_pkg::rsp_type o;
      logic [31:0] v [256];
      logic [31:0] x;
      logic [39:0] total, cum;
      logic [39:0] tops [5];
      logic [8:0]  need [5];
      bit          hit [5];
      int          lim, i, j, k;
      o = '0;
      lim = (expert_limit_reg > 256) ? 256 : int'(expert_limit_reg);
      if (r.opcode == erhp_pkg::OP_RECORD) begin
         if (r.expert_id < 0 || r.expert_id >= lim) begin
            o.status = erhp_pkg::STATUS_IGNORED;
         end else begin
            o.status = erhp_pkg::STATUS_RECORDED;
            if (hist[r.layer][r.expert_id] != '1)
               hist[r.layer][r.expert_id] = hist[r.layer][r.expert_id] + 1;
         end
         return o;
      end
      o.status = erhp_pkg::STATUS_REPORT;
      total = '0;
      for (i = 0; i < 256; i++) begin
         v[i] = hist[r.layer][i];
         total = sat_sum(total, v[i]);
      end
      if (total == 0) return o;
      for (i = 1; i < 256; i++) begin
         x = v[i];
         j = i;
         while (j > 0 && v[j-1] < x) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = x;
      end
      cum = '0;
      for (k = 0; k < 5; k++) begin
         hit[k] = 0;
         tops[k] = '0;
         need[k] = '0;
      end
      for (i = 0; i < 256; i++) begin
         cum = sat_sum(cum, v[i]);
         for (k = 0; k < 5; k++) begin
            if (i + 1 == erhp_pkg::TOP_K[k]) tops[k] = cum;
            if (!hit[k] && 64'(cum) * 100 >= 64'(total) * erhp_pkg::PCT[k]) begin
               hit[k] = 1;
               need[k] = 9'(i + 1);
            end
         end
      end
      o.layer_total = total;
      o.top8_sum = tops[0];
      o.top16_sum = tops[1];
      o.top32_sum = tops[2];
      o.top64_sum = tops[3];
      o.top128_sum = tops[4];
      o.experts_for_half = need[0];
      o.experts_for_eighty = need[1];
      o.experts_for_ninety = need[2];
      o.experts_for_ninety_five = need[3];
      o.experts_for_ninety_nine = need[4];
      return o;
   endfunction

   function automatic void check_field(string name, logic [39:0] e, logic [39:0] a);
      if (e !== a) begin
         $error("%s mismatch: expected %0h actual %0h", name, e, a);
         errors++;
      end
   endfunction

   // driver: beats change on the falling edge
   always @(negedge clock) begin
      if (reset || pending_beats.size() == 0) begin
         start <= 1'b0;
      end else if ((idle_mode == 1 && $urandom_range(0, 99) < 59) ||
                   (idle_mode == 2 && $urandom_range(0, 99) < 8)) begin
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_data <= pending_beats[0];
      end
   end

   // monitor: accept beats and check results on the rising edge
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_rsps.push_back(histogram_response(req_data));
         void'(pending_beats.pop_front());
      end
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("result with no beat outstanding");
            errors++;
         end else begin
            erhp_pkg::rsp_type e;
            e = expected_rsps.pop_front();
            check_field("status", e.status, rsp_data.status);
            check_field("layer_total", e.layer_total, rsp_data.layer_total);
            check_field("top8_sum", e.top8_sum, rsp_data.top8_sum);
            check_field("top16_sum", e.top16_sum, rsp_data.top16_sum);
            check_field("top32_sum", e.top32_sum, rsp_data.top32_sum);
            check_field("top64_sum", e.top64_sum, rsp_data.top64_sum);
            check_field("top128_sum", e.top128_sum, rsp_data.top128_sum);
            check_field("experts_for_half", e.experts_for_half, rsp_data.experts_for_half);
            check_field("experts_for_eighty", e.experts_for_eighty,
                        rsp_data.experts_for_eighty);
            check_field("experts_for_ninety", e.experts_for_ninety,
                        rsp_data.experts_for_ninety);
            check_field("experts_for_ninety_five", e.experts_for_ninety_five,
                        rsp_data.experts_for_ninety_five);
            check_field("experts_for_ninety_nine", e.experts_for_ninety_nine,
                        rsp_data.experts_for_ninety_nine);
         end
      end
   end

   // watchdog covers the clearing pass and the longest report scan
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("expert_route_histogram_profiler test failed");
         $finish;
      end
   end

   function automatic void add_beat(erhp_pkg::opcode_type op, int layer, int id);
      erhp_pkg::req_type r;
      r.opcode = op;
      r.layer = 6'(layer);
      r.expert_id = id;
      pending_beats.push_back(r);
   endfunction

   task automatic write_expert_count(logic [8:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      expert_limit_reg = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      wait (pending_beats.size() == 0 && expected_rsps.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_beats(int n);
      int i, sel, layer, id;
      for (i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         layer = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
         if (sel < 5) begin
            add_beat(erhp_pkg::OP_REPORT, layer, $urandom);
         end else if (sel < 15) begin
            add_beat(erhp_pkg::OP_RECORD, layer, $urandom);
         end else if (sel < 20) begin
            add_beat(erhp_pkg::OP_RECORD, layer, $urandom_range(0, 300));
         end else begin
            // picks with ids 0 to 255, skewed toward a few hot experts
            id = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
            add_beat(erhp_pkg::OP_RECORD, layer, id);
         end
      end
   endtask

   initial begin
      for (int l = 0; l < 64; l++)
         for (int e = 0; e < 256; e++) hist[l][e] = '0;
      expert_limit_reg = erhp_pkg::EXPERT_COUNT_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, sign bit, bounds, empty layer
      add_beat(erhp_pkg::OP_REPORT, 0, 0);
      add_beat(erhp_pkg::OP_RECORD, 0, 0);
      add_beat(erhp_pkg::OP_RECORD, 0, 255);
      add_beat(erhp_pkg::OP_RECORD, 0, 255);
      add_beat(erhp_pkg::OP_RECORD, 0, 256);
      add_beat(erhp_pkg::OP_RECORD, 0, -1);
      add_beat(erhp_pkg::OP_RECORD, 0, 32'h7fffffff);
      add_beat(erhp_pkg::OP_RECORD, 0, 32'h80000000);
      add_beat(erhp_pkg::OP_RECORD, 63, 3);
      add_beat(erhp_pkg::OP_RECORD, 63, 3);
      add_beat(erhp_pkg::OP_REPORT, 0, -1);
      add_beat(erhp_pkg::OP_REPORT, 5, 0);
      add_beat(erhp_pkg::OP_REPORT, 63, 0);
      drain();
      write_expert_count(9'd0);
      add_beat(erhp_pkg::OP_RECORD, 1, 0);
      drain();
      write_expert_count(9'd511);
      add_beat(erhp_pkg::OP_RECORD, 1, 255);
      add_beat(erhp_pkg::OP_RECORD, 1, 256);
      drain();
      // lowered count: report still covers counters above it
      write_expert_count(9'd4);
      add_beat(erhp_pkg::OP_RECORD, 0, 3);
      add_beat(erhp_pkg::OP_RECORD, 0, 4);
      add_beat(erhp_pkg::OP_REPORT, 0, 0);
      drain();
      write_expert_count(9'd1);
      add_beat(erhp_pkg::OP_RECORD, 2, 0);
      add_beat(erhp_pkg::OP_RECORD, 2, 1);
      add_beat(erhp_pkg::OP_REPORT, 2, 0);
      drain();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: write_expert_count(9'd256);
            1: write_expert_count(9'd1);
            2: write_expert_count(9'($urandom_range(1, 256)));
            3: write_expert_count(9'd16);
            default: write_expert_count(9'd300);
         endcase
         idle_mode = p % 3;
         random_beats(140);
         drain();
      end

      repeat (50) @(negedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("expert_route_histogram_profiler test passed");
      end else begin
         $display("expert_route_histogram_profiler test failed");
      end
      $finish;
   end

endmodule

// File: files.f
src/erhp_pkg.sv
src/erhp_count_ram.sv
src/expert_route_histogram_profiler.sv
bench/tb_expert_route_histogram_profiler.sv
